// ===== sv/vpds_pkg.sv =====
// Shared types and constants of the vertex projection and diffuse shading block.
// Holds register indexes, reset values, the length unit's states and the pipeline map.
// No dependencies.
package vpds_pkg;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERSP   = 4'd0,
    REG_MARGINS = 4'd1,
    REG_DEPTH   = 4'd2,
    REG_LIGHT_X = 4'd3,
    REG_LIGHT_Y = 4'd4,
    REG_LIGHT_Z = 4'd5,
    REG_INTENS  = 4'd6,
    REG_BASE    = 4'd7
  } cfg_reg_e;

  // Register reset values.
  localparam logic        PERSP_RST   = 1'b1;
  localparam logic [31:0] MARGINS_RST = 32'd0;
  localparam logic [30:0] DEPTH_RST   = 31'd65536000;
  localparam logic [31:0] LIGHT_X_RST = 32'd0;
  localparam logic [31:0] LIGHT_Y_RST = 32'd0;
  localparam logic [31:0] LIGHT_Z_RST = 32'd65536000;
  localparam logic [31:0] INTENS_RST  = 32'd65536;
  localparam logic [23:0] BASE_RST    = 24'hFFFFFF;

  // Light vector length for the reset light position.
  localparam logic [31:0] LEN_RST = 32'd65536000;

  // States of the light length unit.
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SUM,
    SQ_ROOT
  } sq_state_e;

  // Pipeline map: three front stages, the long divider, three post stages,
  // then the color quotient stages, the last of which is the output register.
  localparam int unsigned S_PRE1  = 0;
  localparam int unsigned S_PRE2  = 1;
  localparam int unsigned S_DIVIN = 2;
  localparam int unsigned DIV_M_N = 50;
  localparam int unsigned DIV_P_N = 34;
  localparam int unsigned S_P1    = S_DIVIN + DIV_M_N + 1;
  localparam int unsigned S_P2    = S_P1 + 1;
  localparam int unsigned S_P3    = S_P2 + 1;
  localparam int unsigned S_CD0   = S_P3 + 1;
  localparam int unsigned CD_N    = 8;
  localparam int unsigned NST     = S_CD0 + CD_N + 1;

endpackage

// ===== sv/vpds_intf.sv =====
// Channel interfaces of the vertex projection and diffuse shading block.
// Vertex input, result output and configuration write; depends on vpds_pkg.

// Vertex input channel.
interface vpds_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                output ready);
endinterface

// Result output channel.
interface vpds_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] screen_z;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  modport source (output valid, screen_x, screen_y, screen_z, red, green, blue,
                  input ready);
  modport sink (input valid, screen_x, screen_y, screen_z, red, green, blue,
                output ready);
endinterface

// Configuration write channel.
interface vpds_cfg_if
  import vpds_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/vertex_project_and_diffuse_shade_top.sv =====
// Top level of the vertex projection and diffuse shading block.
// Uses vpds_pkg, the channel interfaces and vpds_len_sqrt.
//
//   Port   Direction  Moves per transaction
//   vtx    in         one vertex: position (Q16.16) and normal (Q2.14)
//   res    out        screen position (Q16.16) and diffuse color (8 bits each)
//   cfg    in         one register write: index and data
//
// One vertex enters per cycle while the length unit is idle and no stall at res holds the pipeline.
// The depth is set by the 50-step shading divider, which runs beside the 34-step
// projection divider. A write to a light register starts the length unit,
// which holds cfg.ready and vtx.ready low while it runs.
// Reset clears the valid bits and loads the configuration reset values; a stall at res
// collapses bubbles stage by stage and freezes the rest without losing a vertex.
module vertex_project_and_diffuse_shade_top
  import vpds_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  vpds_vtx_if.sink  vtx,
  vpds_res_if.source res,
  vpds_cfg_if.sink  cfg
);

  // Divider stage payload.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][32:0] prem;
    logic [2:0][33:0] plo;
    logic [2:0]       pneg;
    logic [2:0]       povf;
    logic [32:0]      ad;
    logic [31:0]      mrem;
    logic [49:0]      mlo;
    logic [50:0]      r2;
  } div_t;

  // Color quotient stage payload.
  typedef struct packed {
    logic [2:0][31:0] scr;
    logic [2:0][73:0] rem;
    logic [2:0][7:0]  q;
    logic [2:0]       ovf;
    logic [2:0]       nz;
    logic [50:0]      r2;
  } cd_t;

  localparam logic [33:0] POVF_MAG = 34'h2_0000_0000;

  // One projection and one shading quotient bit.
  function automatic div_t div_step(div_t s, logic do_p, logic [31:0] len);
    div_t        r;
    logic [33:0] t;
    logic [32:0] tm;
    logic        qb;
    r = s;
    if (do_p) begin
      for (int i = 0; i < 3; i++) begin
        t = {s.prem[i], s.plo[i][33]};
        if (t >= {1'b0, s.ad}) begin
          r.prem[i] = 33'(t - {1'b0, s.ad});
          qb = 1'b1;
        end else begin
          r.prem[i] = t[32:0];
          qb = 1'b0;
        end
        r.plo[i] = {s.plo[i][32:0], qb};
      end
    end
    tm = {s.mrem, s.mlo[49]};
    if (tm >= {1'b0, len}) begin
      r.mrem = 32'(tm - {1'b0, len});
      qb = 1'b1;
    end else begin
      r.mrem = tm[31:0];
      qb = 1'b0;
    end
    r.mlo = {s.mlo[48:0], qb};
    return r;
  endfunction

  // One color quotient bit at weight 2^sh.
  function automatic cd_t cd_step(cd_t s, int unsigned sh);
    cd_t         r;
    logic [73:0] cmp;
    r   = s;
    cmp = {23'd0, s.r2} << sh;
    for (int i = 0; i < 3; i++) begin
      if (s.rem[i] >= cmp) begin
        r.rem[i]   = s.rem[i] - cmp;
        r.q[i][sh] = 1'b1;
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic               persp_q;
  logic [31:0]        margins_q;
  logic [30:0]        depth_q;
  logic signed [31:0] lx_q, ly_q, lz_q;
  logic [31:0]        inten_q;
  logic [23:0]        base_q;

  logic        cfg_fire;
  logic        sq_start;
  logic        sq_busy;
  logic [31:0] len;

  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cfg.ready = !sq_busy;
  assign sq_start  = cfg_fire && (cfg.index == REG_LIGHT_X || cfg.index == REG_LIGHT_Y ||
                                  cfg.index == REG_LIGHT_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persp_q   <= PERSP_RST;
      margins_q <= MARGINS_RST;
      depth_q   <= DEPTH_RST;
      lx_q      <= LIGHT_X_RST;
      ly_q      <= LIGHT_Y_RST;
      lz_q      <= LIGHT_Z_RST;
      inten_q   <= INTENS_RST;
      base_q    <= BASE_RST;
    end else if (cfg_fire) begin
      case (cfg.index)
        REG_PERSP:   persp_q   <= cfg.data[0];
        REG_MARGINS: margins_q <= cfg.data;
        REG_DEPTH:   depth_q   <= cfg.data[30:0];
        REG_LIGHT_X: lx_q      <= cfg.data;
        REG_LIGHT_Y: ly_q      <= cfg.data;
        REG_LIGHT_Z: lz_q      <= cfg.data;
        REG_INTENS:  inten_q   <= cfg.data;
        REG_BASE:    base_q    <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // Light vector length, recomputed after each light write.
  vpds_len_sqrt u_len (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .light_x_i (lx_q),
    .light_y_i (ly_q),
    .light_z_i (lz_q),
    .busy_o    (sq_busy),
    .len_o     (len)
  );

  // Pipeline flow control: a stage advances when empty or when the next one does.
  logic [NST-1:0] vld_q, vld_d, adv;
  logic           vtx_fire;

  assign adv[NST-1] = !vld_q[NST-1] || res.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  assign vtx.ready = adv[S_PRE1] && !sq_busy;
  assign vtx_fire  = vtx.valid && vtx.ready;

  always_comb begin
    vld_d[0] = adv[0] ? vtx_fire : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Front stage one: products with the depth scale, deltas to the light, N*L terms.
  logic signed [31:0] pin [3];
  logic signed [15:0] nin [3];
  logic signed [31:0] lgt [3];
  logic [30:0]        c_eff;
  logic signed [31:0] c_s;

  logic signed [63:0] num_d [3];
  logic signed [33:0] d_d;
  logic signed [32:0] dl_d [3];
  logic signed [47:0] nl_d [3];

  logic [31:0]        p0_pos_q [3];
  logic signed [63:0] p0_num_q [3];
  logic signed [33:0] p0_d_q;
  logic signed [32:0] p0_dl_q [3];
  logic signed [47:0] p0_nl_q [3];

  always_comb begin
    pin[0] = vtx.pos_x;
    pin[1] = vtx.pos_y;
    pin[2] = vtx.pos_z;
    nin[0] = vtx.normal_x;
    nin[1] = vtx.normal_y;
    nin[2] = vtx.normal_z;
    lgt[0] = lx_q;
    lgt[1] = ly_q;
    lgt[2] = lz_q;
    c_eff  = (depth_q == '0) ? 31'd1 : depth_q;
    c_s    = signed'({1'b0, c_eff});
    d_d    = 34'(c_s) - 34'(pin[2]);
    for (int i = 0; i < 3; i++) begin
      num_d[i] = pin[i] * c_s;
      dl_d[i]  = 33'(lgt[i]) - 33'(pin[i]);
      nl_d[i]  = nin[i] * lgt[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_PRE1]) begin
      for (int i = 0; i < 3; i++) begin
        p0_pos_q[i] <= pin[i];
        p0_num_q[i] <= num_d[i];
        p0_dl_q[i]  <= dl_d[i];
        p0_nl_q[i]  <= nl_d[i];
      end
      p0_d_q <= d_d;
    end
  end

  // Front stage two: magnitudes and signs, overflow test, squared distances, N.L.
  logic [62:0]        an_d [3];
  logic [32:0]        ad_d;
  logic [2:0]         ovf_d, neg_d;
  logic [32:0]        adl;
  logic [65:0]        prod;
  logic [48:0]        sq_d [3];
  logic signed [49:0] dot_d;

  logic [31:0]        p1_pos_q [3];
  logic [62:0]        p1_an_q [3];
  logic [2:0]         p1_ovf_q, p1_neg_q;
  logic [32:0]        p1_ad_q;
  logic [48:0]        p1_sq_q [3];
  logic signed [49:0] p1_dot_q;

  always_comb begin
    ad_d  = p0_d_q[33] ? 33'(-p0_d_q) : 33'(p0_d_q);
    dot_d = 50'(p0_nl_q[0]) + 50'(p0_nl_q[1]) + 50'(p0_nl_q[2]);
    adl   = '0;
    prod  = '0;
    for (int i = 0; i < 3; i++) begin
      an_d[i]  = p0_num_q[i][63] ? 63'(-p0_num_q[i]) : 63'(p0_num_q[i]);
      ovf_d[i] = (p0_num_q[i] != 64'sd0) && ({4'd0, an_d[i][62:34]} >= ad_d);
      neg_d[i] = p0_num_q[i][63] ^ p0_d_q[33];
      adl      = p0_dl_q[i][32] ? 33'(-p0_dl_q[i]) : 33'(p0_dl_q[i]);
      prod     = adl * adl;
      sq_d[i]  = prod[64:16];
    end
  end

  // On the eye plane every nonzero coordinate already saturates, so a divisor
  // of one lets a zero coordinate come out as zero.
  always_ff @(posedge clk_i) begin
    if (adv[S_PRE2]) begin
      for (int i = 0; i < 3; i++) begin
        p1_pos_q[i] <= p0_pos_q[i];
        p1_an_q[i]  <= an_d[i];
        p1_sq_q[i]  <= sq_d[i];
      end
      p1_ovf_q <= ovf_d;
      p1_neg_q <= neg_d;
      p1_ad_q  <= (ad_d == '0) ? 33'd1 : ad_d;
      p1_dot_q <= dot_d;
    end
  end

  // Divider entry: distance sum and the shading dividend.
  div_t dv_init;
  div_t dv_q [DIV_M_N+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_init.pos[i]  = p1_pos_q[i];
      dv_init.prem[i] = {4'd0, p1_an_q[i][62:34]};
      dv_init.plo[i]  = p1_an_q[i][33:0];
    end
    dv_init.pneg = p1_neg_q;
    dv_init.povf = p1_ovf_q;
    dv_init.ad   = p1_ad_q;
    dv_init.mrem = '0;
    dv_init.mlo  = (p1_dot_q > 50'sd0) ? {p1_dot_q[47:0], 2'b00} : '0;
    dv_init.r2   = 51'(p1_sq_q[0]) + 51'(p1_sq_q[1]) + 51'(p1_sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_DIVIN]) begin
      dv_q[0] <= dv_init;
    end
  end

  // Divider stages: one shading quotient bit per stage, and one projection bit in each of the first DIV_P_N.
  for (genvar j = 0; j < DIV_M_N; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv[S_DIVIN+j+1]) begin
        dv_q[j+1] <= div_step(dv_q[j], (j < DIV_P_N), len);
      end
    end
  end

  // Post stage one: signed quotients or raw positions, margins, saturation; intensity products.
  div_t               dl;
  logic [33:0]        q34;
  logic signed [35:0] sv;
  logic [31:0]        marg;
  logic signed [36:0] sum;
  logic [31:0]        scr_d [3];
  logic [49:0]        m50;
  logic [63:0]        pa_d;
  logic [49:0]        pb_d;

  logic [31:0] pm_scr_q [3];
  logic [63:0] pm_pa_q;
  logic [49:0] pm_pb_q;
  logic [50:0] pm_r2_q;

  always_comb begin
    dl   = dv_q[DIV_M_N];
    q34  = '0;
    sv   = '0;
    marg = '0;
    sum  = '0;
    for (int i = 0; i < 3; i++) begin
      q34 = dl.povf[i] ? POVF_MAG : dl.plo[i];
      sv  = dl.pneg[i] ? -$signed({2'b00, q34}) : $signed({2'b00, q34});
      if (!persp_q) begin
        sv = 36'($signed(dl.pos[i]));
      end
      case (i)
        0:       marg = {margins_q[15:0], 16'h0};
        1:       marg = {margins_q[31:16], 16'h0};
        default: marg = '0;
      endcase
      sum = 37'(sv) + $signed({5'd0, marg});
      if (sum > 37'sd2147483647) begin
        scr_d[i] = 32'h7FFF_FFFF;
      end else if (sum < -37'sd2147483648) begin
        scr_d[i] = 32'h8000_0000;
      end else begin
        scr_d[i] = sum[31:0];
      end
    end
    m50  = (len == '0) ? '0 : dl.mlo;
    pa_d = inten_q * m50[31:0];
    pb_d = inten_q * m50[49:32];
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_P1]) begin
      for (int i = 0; i < 3; i++) begin
        pm_scr_q[i] <= scr_d[i];
      end
      pm_pa_q <= pa_d;
      pm_pb_q <= pb_d;
      pm_r2_q <= dl.r2;
    end
  end

  // Post stage two: assemble intensity times the cosine term.
  logic [31:0] px_scr_q [3];
  logic [81:0] px_x_q;
  logic [50:0] px_r2_q;

  always_ff @(posedge clk_i) begin
    if (adv[S_P2]) begin
      for (int i = 0; i < 3; i++) begin
        px_scr_q[i] <= pm_scr_q[i];
      end
      px_x_q  <= 82'(pm_pa_q) + {pm_pb_q, 32'd0};
      px_r2_q <= pm_r2_q;
    end
  end

  // Post stage three: scale by each base color channel.
  logic [7:0]  bch [3];
  logic [89:0] nfull [3];

  logic [31:0] pn_scr_q [3];
  logic [73:0] pn_nh_q [3];
  logic [2:0]  pn_nz_q;
  logic [50:0] pn_r2_q;

  always_comb begin
    bch[0] = base_q[23:16];
    bch[1] = base_q[15:8];
    bch[2] = base_q[7:0];
    for (int i = 0; i < 3; i++) begin
      nfull[i] = px_x_q * bch[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_P3]) begin
      for (int i = 0; i < 3; i++) begin
        pn_scr_q[i] <= px_scr_q[i];
        pn_nh_q[i]  <= nfull[i][89:16];
        pn_nz_q[i]  <= (nfull[i] != '0);
      end
      pn_r2_q <= px_r2_q;
    end
  end

  // Color quotient entry: saturation test against 256 times the squared distance.
  cd_t cd_init;
  cd_t cd_q [CD_N+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd_init.scr[i] = pn_scr_q[i];
      cd_init.rem[i] = pn_nh_q[i];
      cd_init.q[i]   = '0;
      cd_init.ovf[i] = (pn_nh_q[i] >= {15'd0, pn_r2_q, 8'd0});
    end
    cd_init.nz = pn_nz_q;
    cd_init.r2 = pn_r2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_CD0]) begin
      cd_q[0] <= cd_init;
    end
  end

  // Color quotient stages, most significant bit first; the last is the output register.
  for (genvar k = 0; k < CD_N; k++) begin : g_cd
    always_ff @(posedge clk_i) begin
      if (adv[S_CD0+k+1]) begin
        cd_q[k+1] <= cd_step(cd_q[k], CD_N - 1 - k);
      end
    end
  end

  // Result channel.
  logic [7:0] col [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!cd_q[CD_N].nz[i]) begin
        col[i] = 8'd0;
      end else if (cd_q[CD_N].ovf[i]) begin
        col[i] = 8'hFF;
      end else begin
        col[i] = cd_q[CD_N].q[i];
      end
    end
  end

  assign res.valid    = vld_q[NST-1];
  assign res.screen_x = cd_q[CD_N].scr[0];
  assign res.screen_y = cd_q[CD_N].scr[1];
  assign res.screen_z = cd_q[CD_N].scr[2];
  assign res.red      = col[0];
  assign res.green    = col[1];
  assign res.blue     = col[2];

endmodule

// ===== sv/vpds_len_sqrt.sv =====
// Light vector length unit: floor(sqrt(lx^2 + ly^2 + lz^2)) for the light position.
// Sums the three squared components, then runs a 32-step restoring square root; depends on vpds_pkg.
module vpds_len_sqrt
  import vpds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] light_x_i,
  input  logic signed [31:0] light_y_i,
  input  logic signed [31:0] light_z_i,
  output logic               busy_o,
  output logic [31:0]        len_o
);

  sq_state_e   state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] root_q, root_d;
  logic [31:0] len_q, len_d;

  logic signed [31:0] comp;
  logic [31:0]        mag;
  logic [63:0]        sq;
  logic [63:0]        bitv;
  logic [63:0]        trial;

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      cnt_q   <= '0;
      len_q   <= LEN_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    root_q <= root_d;
  end

  // Operand selection for the squaring and root steps.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    comp = light_x_i;
      2'd1:    comp = light_y_i;
      default: comp = light_z_i;
    endcase
    mag   = comp[31] ? 32'(-comp) : 32'(comp);
    sq    = mag * mag;
    bitv  = 64'd1 << (6'd62 - {cnt_q, 1'b0});
    trial = root_q + bitv;
  end

  // Next state and outputs.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    root_d  = root_q;
    len_d   = len_q;
    case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          state_d = SQ_SUM;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      SQ_SUM: begin
        acc_d = acc_q + sq;
        if (cnt_q == 5'd2) begin
          state_d = SQ_ROOT;
          cnt_d   = '0;
          root_d  = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      SQ_ROOT: begin
        if (acc_q >= trial) begin
          acc_d  = acc_q - trial;
          root_d = (root_q >> 1) + bitv;
        end else begin
          root_d = root_q >> 1;
        end
        if (cnt_q == 5'd31) begin
          len_d   = root_d[31:0];
          state_d = SQ_IDLE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  assign busy_o = (state_q != SQ_IDLE);
  assign len_o  = len_q;

endmodule

// ===== sv/vpds_checker.sv =====
// Port-level checker for the vertex projection and diffuse shading top level.
// Bound to vertex_project_and_diffuse_shade_top; depends on vpds_pkg.
module vpds_checker
  import vpds_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 vtx_ready_i,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic [119:0]         res_data_i
);

  // A stalled result stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // A light write starts the length unit, which blocks the next write.
  a_light_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i &&
    (cfg_index_i == REG_LIGHT_X || cfg_index_i == REG_LIGHT_Y ||
     cfg_index_i == REG_LIGHT_Z) |=> !cfg_ready_i)
    else $error("light write did not start the length unit");

  // No vertex is taken while the light length is being recomputed.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_i |-> !vtx_ready_i)
    else $error("vertex accepted during length update");

endmodule

bind vertex_project_and_diffuse_shade_top vpds_checker u_vpds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .vtx_ready_i (vtx.ready),
  .cfg_valid_i (cfg.valid),
  .cfg_ready_i (cfg.ready),
  .cfg_index_i (cfg.index),
  .res_valid_i (res.valid),
  .res_ready_i (res.ready),
  .res_data_i  ({res.screen_x, res.screen_y, res.screen_z, res.red, res.green, res.blue})
);

// ===== tb/vpds_checker.sv =====
// Checker for the vertex projection and diffuse shading block.
// Watches the vertex, result and configuration channels, predicts each result and compares it.
// Depends on vpds_pkg and the channel interfaces in vpds_intf.sv.
`timescale 1ns / 100ps

module vpds_scoreboard
  import vpds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vpds_vtx_if         vtx,
  vpds_res_if         res,
  vpds_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked
);

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;

  // Shadow copy of the configuration registers.
  logic               persp_q;
  logic [31:0]        margins_q;
  logic [30:0]        depth_q;
  logic signed [31:0] light_q [3];
  logic [31:0]        intens_q;
  logic [23:0]        base_q;

  pixel_t pixel_fifo[$];

  assign pending = pixel_fifo.size();

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem, root, probe;
    rem   = v;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Perspective divide; on the eye plane the value runs to the extreme of its sign.
  function automatic longint persp_div(longint p, longint c, longint d);
    longint num;
    num = p * c;
    if (d == 0) begin
      if (num > 0) return longint'(1) <<< 40;
      if (num < 0) return -(longint'(1) <<< 40);
      return 0;
    end
    return num / d;
  endfunction

  // One color channel; all products wrap at 64 bits.
  function automatic logic [7:0] diffuse_channel(logic [63:0] base_ch, logic [63:0] x,
                                                 logic [63:0] r2);
    logic [63:0] num, q;
    num = base_ch * x;
    if (r2 == 0) return (num != 0) ? 8'd255 : 8'd0;
    q = (num / r2) >> 16;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_t shade_vertex(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz, logic signed [15:0] nx,
                                          logic signed [15:0] ny, logic signed [15:0] nz);
    pixel_t      o;
    longint      p [3];
    longint      n [3];
    longint      l [3];
    longint      sx, sy, sz, c, d, dot, diff;
    logic [63:0] r2, len2, len, m, x, u;
    p[0] = px; p[1] = py; p[2] = pz;
    n[0] = nx; n[1] = ny; n[2] = nz;
    for (int i = 0; i < 3; i++) l[i] = light_q[i];
    if (persp_q) begin
      c = (depth_q == 0) ? 1 : longint'(depth_q);
      d = c - p[2];
      sx = persp_div(p[0], c, d);
      sy = persp_div(p[1], c, d);
      sz = persp_div(p[2], c, d);
    end else begin
      sx = p[0];
      sy = p[1];
      sz = p[2];
    end
    o.sx = clamp32(sx + longint'(margins_q[15:0]) * 65536);
    o.sy = clamp32(sy + longint'(margins_q[31:16]) * 65536);
    o.sz = clamp32(sz);

    r2 = '0;
    len2 = '0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      diff = l[i] - p[i];
      u = (diff < 0) ? -diff : diff;
      r2 = r2 + ((u * u) >> 16);
      u = (l[i] < 0) ? -l[i] : l[i];
      len2 = len2 + u * u;
      dot = dot + n[i] * l[i];
    end
    len = floor_sqrt(len2);
    m = '0;
    if (dot > 0 && len > 0) m = (64'(dot) << 2) / len;
    x = {32'd0, intens_q} * m;
    o.red   = diffuse_channel({56'd0, base_q[23:16]}, x, r2);
    o.green = diffuse_channel({56'd0, base_q[15:8]}, x, r2);
    o.blue  = diffuse_channel({56'd0, base_q[7:0]}, x, r2);
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH @%0t result %0d %s: got %h want %h", $time, checked, what, got, want);
    mismatches++;
  endtask

  // Register writes, vertex predictions and result comparisons.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      persp_q    <= PERSP_RST;
      margins_q  <= MARGINS_RST;
      depth_q    <= DEPTH_RST;
      light_q[0] <= LIGHT_X_RST;
      light_q[1] <= LIGHT_Y_RST;
      light_q[2] <= LIGHT_Z_RST;
      intens_q   <= INTENS_RST;
      base_q     <= BASE_RST;
    end else begin
      if (res.valid && res.ready) begin
        if (pixel_fifo.size() == 0) begin
          $display("MISMATCH @%0t result with no vertex outstanding", $time);
          mismatches++;
        end else begin
          want = pixel_fifo.pop_front();
          if (res.screen_x !== want.sx) report("screen_x", res.screen_x, want.sx);
          if (res.screen_y !== want.sy) report("screen_y", res.screen_y, want.sy);
          if (res.screen_z !== want.sz) report("screen_z", res.screen_z, want.sz);
          if (res.red !== want.red) report("red", res.red, want.red);
          if (res.green !== want.green) report("green", res.green, want.green);
          if (res.blue !== want.blue) report("blue", res.blue, want.blue);
          checked++;
        end
      end
      if (vtx.valid && vtx.ready)
        pixel_fifo.push_back(shade_vertex(vtx.pos_x, vtx.pos_y, vtx.pos_z,
                                          vtx.normal_x, vtx.normal_y, vtx.normal_z));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PERSP:   persp_q    <= cfg.data[0];
          REG_MARGINS: margins_q  <= cfg.data;
          REG_DEPTH:   depth_q    <= cfg.data[30:0];
          REG_LIGHT_X: light_q[0] <= cfg.data;
          REG_LIGHT_Y: light_q[1] <= cfg.data;
          REG_LIGHT_Z: light_q[2] <= cfg.data;
          REG_INTENS:  intens_q   <= cfg.data;
          REG_BASE:    base_q     <= cfg.data[23:0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    mismatches = 0;
    checked = 0;
  end

endmodule

// ===== tb/tb_vertex_project_and_diffuse_shade_top.sv =====
// Testbench top for the vertex projection and diffuse shading block.
// Drives vertices and register writes with random pacing; vpds_scoreboard predicts and compares.
// Depends on vpds_pkg, vpds_intf.sv, the block and tb/vpds_checker.sv.
`timescale 1ns / 100ps

module tb_vertex_project_and_diffuse_shade_top;
  import vpds_pkg::*;

  logic clk_i;
  logic rst_ni;

  vpds_vtx_if vtx ();
  vpds_res_if res ();
  vpds_cfg_if cfg ();

  int unsigned mismatches, pending, checked;
  int unsigned vertices_sent, phases_run;
  bit          press_req, press_done;

  // Stimulus-side view of the settings that shape the vertex mix.
  logic [30:0]        depth_cur;
  logic signed [31:0] light_cur [3];

  vertex_project_and_diffuse_shade_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx   (vtx),
    .res   (res),
    .cfg   (cfg)
  );

  vpds_scoreboard checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vtx       (vtx),
    .res       (res),
    .cfg       (cfg),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Overall time limit.
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: randomly chosen stall patterns, plus one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned cyc;
    res.ready = 1'b0;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      if (press_req && !press_done) begin
        res.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        press_done = 1'b1;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
          0: res.ready <= 1'b1;
          1: res.ready <= ($urandom_range(0, 3) != 0);
          2: res.ready <= ($urandom_range(0, 3) == 0);
          default: res.ready <= (cyc % 8 < 5);
        endcase
      end
    end
  end

  // Register write over the configuration channel; called at a falling edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg.index <= idx;
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    case (idx)
      REG_DEPTH:   depth_cur    = value[30:0];
      REG_LIGHT_X: light_cur[0] = value;
      REG_LIGHT_Y: light_cur[1] = value;
      REG_LIGHT_Z: light_cur[2] = value;
      default: ;
    endcase
  endtask

  // Wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    vtx.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // One vertex transaction, optionally preceded by an idle gap; called at a falling edge.
  task automatic send_vertex(int unsigned gap, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [15:0] nx, logic [15:0] ny,
                             logic [15:0] nz);
    if (gap != 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vtx.pos_x    <= px;
    vtx.pos_y    <= py;
    vtx.pos_z    <= pz;
    vtx.normal_x <= nx;
    vtx.normal_y <= ny;
    vtx.normal_z <= nz;
    vtx.valid    <= 1'b1;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    @(negedge clk_i);
    vertices_sent++;
  endtask

  function automatic logic [31:0] pick_coord(int unsigned axis);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 2 << 20) - (1 << 20);
      3:       return $urandom_range(0, 4) - 2;
      4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      5:       return light_cur[axis] + $urandom_range(0, 4) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  // Random vertices in bursts; near the eye plane or the light now and then.
  task automatic random_vertices(int unsigned count, bit with_press);
    int unsigned burst;
    int unsigned gap;
    logic [31:0] px, py, pz;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      gap = 0;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst--;
      if (with_press && i == count / 2) press_req = 1'b1;
      px = pick_coord(0);
      py = pick_coord(1);
      pz = pick_coord(2);
      if ($urandom_range(0, 15) == 0) pz = {1'b0, depth_cur} + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 31) == 0) begin
        px = light_cur[0];
        py = light_cur[1];
        pz = light_cur[2];
      end
      send_vertex(gap, px, py, pz, pick_normal(), pick_normal(), pick_normal());
    end
  endtask

  task automatic random_settings();
    write_reg(REG_PERSP, $urandom);
    write_reg(REG_MARGINS, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535));
    write_reg(REG_DEPTH, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 24));
    write_reg(REG_LIGHT_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 26));
    write_reg(REG_LIGHT_Y, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 26));
    write_reg(REG_LIGHT_Z, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 26));
    write_reg(REG_INTENS, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
    write_reg(REG_BASE, $urandom);
  endtask

  // Main stimulus sequence.
  initial begin
    vtx.valid    = 1'b0;
    vtx.pos_x    = '0;
    vtx.pos_y    = '0;
    vtx.pos_z    = '0;
    vtx.normal_x = '0;
    vtx.normal_y = '0;
    vtx.normal_z = '0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
    press_req    = 1'b0;
    press_done   = 1'b0;
    vertices_sent = 0;
    phases_run   = 0;
    depth_cur    = DEPTH_RST;
    light_cur[0] = LIGHT_X_RST;
    light_cur[1] = LIGHT_Y_RST;
    light_cur[2] = LIGHT_Z_RST;
    rst_ni       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // Directed vertices under reset settings: extremes, eye plane, light at the vertex.
    send_vertex(0, 0, 0, 0, 0, 0, 16384);
    send_vertex(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
    send_vertex(1, 32'h0001_0000, 32'hFFFF_0000, 32'd65536000, 0, 0, 16384);
    send_vertex(0, 32'hFFFF_0000, 32'h0001_0000, 32'd65536000, 0, 0, 16384);
    send_vertex(0, 0, 0, 32'd65536000, 0, 0, 16384);
    send_vertex(0, 0, 0, 32'd65535999, 0, 0, 16384);
    send_vertex(2, 32'h0010_0000, 32'h0020_0000, 32'h0040_0000, 0, 0, 16'hC000);
    send_vertex(0, 32'h0010_0000, 32'h0020_0000, 32'hFFC0_0000, 16'h2000, 16'h2000, 16'h2000);
    send_vertex(0, 32'd100, 32'd200, 32'd65535000, 16'h7FFF, 16'h8000, 16'h4000);
    send_vertex(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 16'h5555, 16'hAAAA, 16'h0001);
    send_vertex(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0001, 16'hAAAA, 16'h5555, 16'hFFFF);
    drain();

    // Flat settings: no perspective, full margins, far light at the positive corner.
    write_reg(REG_PERSP, 32'd0);
    write_reg(REG_MARGINS, 32'hFFFF_FFFF);
    write_reg(REG_DEPTH, 32'h7FFF_FFFF);
    write_reg(REG_LIGHT_X, 32'h7FFF_FFFF);
    write_reg(REG_LIGHT_Y, 32'h7FFF_FFFF);
    write_reg(REG_LIGHT_Z, 32'h7FFF_FFFF);
    write_reg(REG_INTENS, 32'hFFFF_FFFF);
    write_reg(REG_BASE, 32'h0000_0000);
    write_reg(4'd8, 32'hFFFF_FFFF);
    write_reg(4'd15, 32'h1234_5678);
    send_vertex(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h4000, 0, 0);
    send_vertex(0, 32'h8000_0000, 32'h8000_0000, 0, 16'h4000, 16'h4000, 16'h4000);
    random_vertices(180, 1'b0);
    drain();
    phases_run++;

    // Zero depth scale, light at the origin, mid margins.
    write_reg(REG_PERSP, 32'd1);
    write_reg(REG_MARGINS, 32'h0010_0020);
    write_reg(REG_DEPTH, 32'd0);
    write_reg(REG_LIGHT_X, 32'd0);
    write_reg(REG_LIGHT_Y, 32'd0);
    write_reg(REG_LIGHT_Z, 32'd0);
    write_reg(REG_INTENS, 32'd0);
    write_reg(REG_BASE, 32'hFF_FFFF);
    send_vertex(0, 32'd5, 32'hFFFF_FFFB, 32'd1, 16'h4000, 0, 0);
    send_vertex(0, 0, 0, 0, 16'h4000, 16'h4000, 16'h4000);
    random_vertices(180, 1'b0);
    drain();
    phases_run++;

    // Largest depth, light at the negative corner, strong light; long receiver hold-off.
    write_reg(REG_DEPTH, 32'h7FFF_FFFF);
    write_reg(REG_LIGHT_X, 32'h8000_0000);
    write_reg(REG_LIGHT_Y, 32'h8000_0000);
    write_reg(REG_LIGHT_Z, 32'h8000_0000);
    write_reg(REG_INTENS, 32'h0100_0000);
    write_reg(REG_BASE, 32'h80_40FF);
    random_vertices(240, 1'b1);
    drain();
    phases_run++;

    // Nearby light with modest intensity so colors land inside the range.
    write_reg(REG_MARGINS, 32'h0000_0000);
    write_reg(REG_DEPTH, 32'd65536000);
    write_reg(REG_LIGHT_X, 32'h0002_0000);
    write_reg(REG_LIGHT_Y, 32'h0003_0000);
    write_reg(REG_LIGHT_Z, 32'h0004_0000);
    write_reg(REG_INTENS, 32'h0040_0000);
    random_vertices(200, 1'b0);
    drain();
    phases_run++;

    // Random settings.
    for (int k = 0; k < 3; k++) begin
      random_settings();
      random_vertices(170, 1'b0);
      drain();
      phases_run++;
    end

    $display("Sent %0d vertices over %0d register settings, %0d results compared.",
             vertices_sent, phases_run + 1, checked);
    $display("Covered eye plane, light at origin and at vertex, zero depth, long output stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== vertex_project_and_diffuse_shade_top.f =====
sv/vpds_pkg.sv
sv/vpds_intf.sv
sv/vpds_len_sqrt.sv
sv/vertex_project_and_diffuse_shade_top.sv
sv/vpds_checker.sv
tb/vpds_checker.sv
tb/tb_vertex_project_and_diffuse_shade_top.sv
